// ===== rtl/vsr_pkg.sv =====
// Shared types, codes and widths of the voxel shape rasterizer.
package vsr_pkg;

    // Default grid size on each axis.
    localparam int GRID_X_DEF = 32;
    localparam int GRID_Y_DEF = 32;
    localparam int GRID_Z_DEF = 32;

    // Field widths.
    localparam int COORD_W = 10;
    localparam int RAD_W   = 8;
    localparam int COLOR_W = 8;
    localparam int WIDE_W  = 12;   // coordinate plus or minus a radius, signed
    localparam int SQ_W    = 16;   // square of a radius or an offset
    localparam int SUM_W   = 18;   // sum of three squares
    localparam int PAIR_W  = 32;   // product of two squares
    localparam int TRIP_W  = 48;   // product of three squares
    localparam int ESUM_W  = 50;   // sum of three triple products

    localparam int S_DATA_W = 88;
    localparam int S_USER_W = 4;
    localparam int M_DATA_W = 40;
    localparam int M_USER_W = 1;

    // Operation codes.
    localparam logic [2:0] OP_READ      = 3'd0;
    localparam logic [2:0] OP_VOXEL     = 3'd1;
    localparam logic [2:0] OP_BOX       = 3'd2;
    localparam logic [2:0] OP_SPHERE    = 3'd3;
    localparam logic [2:0] OP_ELLIPSOID = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RED   = 2'd0;
    localparam logic [1:0] CFG_GREEN = 2'd1;
    localparam logic [1:0] CFG_BLUE  = 2'd2;
    localparam logic [1:0] CFG_ALPHA = 2'd3;

    localparam logic [COLOR_W-1:0] COLOR_RESET = 8'hFF;

    // Result status codes.
    localparam logic STATUS_DONE   = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef enum logic [1:0] {
        KIND_BOX,
        KIND_SPHERE,
        KIND_ELLIPSOID
    } vsr_kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SQUARE,
        ST_PAIR,
        ST_TRIPLE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } vsr_state_t;

    typedef struct packed {
        logic load;
        logic sq_en;
        logic pair_en;
        logic trip_en;
        logic walk_en;
        logic clr_en;
        logic result_load;
    } vsr_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic walk_empty;
        logic walk_last;
        logic pipe_busy;
        logic out_free;
    } vsr_stat_t;

endpackage

// ===== rtl/vsr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module vsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/vsr_ctrl.sv =====
// Command sequencer of the voxel shape rasterizer.
module vsr_ctrl
    import vsr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  vsr_stat_t stat,
    output vsr_cmd_t  cmd
);

    vsr_state_t state_reg;
    vsr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: state_next = ST_PAIR;
            ST_PAIR:   state_next = ST_TRIPLE;
            ST_TRIPLE:
            begin
                state_next = stat.walk_empty ? ST_FINISH : ST_WALK;
            end
            ST_WALK:
            begin
                if (stat.walk_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd             = '0;
        s_tready        = (state_reg == ST_IDLE);
        cmd.load        = (state_reg == ST_IDLE) && s_tvalid;
        cmd.sq_en       = (state_reg == ST_SQUARE);
        cmd.pair_en     = (state_reg == ST_PAIR);
        cmd.trip_en     = (state_reg == ST_TRIPLE);
        cmd.walk_en     = (state_reg == ST_WALK);
        cmd.clr_en      = (state_reg == ST_CLEAR);
        cmd.result_load = (state_reg == ST_FINISH) && stat.out_free;
    end

endmodule

// ===== rtl/vsr_datapath.sv =====
// Datapath of the voxel shape rasterizer: bounds, walk counter, hit pipeline, store, result.
module vsr_datapath
    import vsr_pkg::*;
#(
    parameter int GRID_X = GRID_X_DEF,
    parameter int GRID_Y = GRID_Y_DEF,
    parameter int GRID_Z = GRID_Z_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  vsr_cmd_t            cmd,
    output vsr_stat_t           stat,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [S_USER_W-1:0] s_tuser,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_addr,
    input  logic [COLOR_W-1:0]  cfg_wdata,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic [M_USER_W-1:0] m_tuser
);

    localparam int XW    = (GRID_X > 1) ? $clog2(GRID_X) : 1;
    localparam int YW    = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
    localparam int ZW    = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
    localparam int AW    = XW + YW + ZW;
    localparam int DEPTH = 1 << AW;
    localparam int CW    = 4 * COLOR_W;

    typedef struct packed {
        logic                     empty;
        logic signed [WIDE_W-1:0] lo;
        logic signed [WIDE_W-1:0] hi;
    } span_t;

    // Walk range on one axis, clipped to the grid.
    function automatic span_t clip_span(input logic signed [COORD_W-1:0] a,
                                        input logic signed [COORD_W-1:0] b,
                                        input logic [RAD_W-1:0] r,
                                        input int n);
        span_t                    s;
        logic signed [WIDE_W-1:0] lo;
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] top;
        lo      = WIDE_W'(a) - $signed({{(WIDE_W-RAD_W){1'b0}}, r});
        hi      = WIDE_W'(b) + $signed({{(WIDE_W-RAD_W){1'b0}}, r});
        top     = WIDE_W'(n - 1);
        s.lo    = (lo < 0) ? '0 : lo;
        s.hi    = (hi > top) ? top : hi;
        s.empty = (s.lo > s.hi);
        return s;
    endfunction

    function automatic logic [RAD_W-1:0] abs_low(input logic signed [WIDE_W-1:0] d);
        logic signed [WIDE_W-1:0] m;
        m = (d < 0) ? -d : d;
        return m[RAD_W-1:0];
    endfunction

    // Input unpacking.
    logic [2:0]                in_op;
    logic                      in_erase;
    logic signed [COORD_W-1:0] in_ax, in_ay, in_az, in_bx, in_by, in_bz;
    logic [RAD_W-1:0]          in_rx, in_ry, in_rz;

    assign in_op    = s_tuser[2:0];
    assign in_erase = s_tuser[3];
    assign in_ax    = s_tdata[9:0];
    assign in_ay    = s_tdata[19:10];
    assign in_az    = s_tdata[29:20];
    assign in_bx    = s_tdata[39:30];
    assign in_by    = s_tdata[49:40];
    assign in_bz    = s_tdata[59:50];
    assign in_rx    = s_tdata[67:60];
    assign in_ry    = s_tdata[75:68];
    assign in_rz    = s_tdata[83:76];

    // Bounding volume of the incoming command. A read or a single voxel uses a
    // span of one, so an empty span there means the position is off the grid.
    logic                      is_round;
    logic                      is_reject;
    logic                      walks_op;
    logic [RAD_W-1:0]          sel_rx, sel_ry, sel_rz;
    logic signed [COORD_W-1:0] sel_bx, sel_by, sel_bz;
    span_t                     sx, sy, sz;
    logic                      any_empty;

    always_comb
    begin
        is_round  = (in_op == OP_SPHERE) || (in_op == OP_ELLIPSOID);
        is_reject = (in_op == OP_ELLIPSOID) &&
                    ((in_rx == '0) || (in_ry == '0) || (in_rz == '0));
        walks_op  = (in_op == OP_VOXEL) || (in_op == OP_BOX) || (in_op == OP_SPHERE) ||
                    ((in_op == OP_ELLIPSOID) && !is_reject);
        sel_rx    = is_round ? in_rx : '0;
        sel_ry    = (in_op == OP_SPHERE) ? in_rx : ((in_op == OP_ELLIPSOID) ? in_ry : '0);
        sel_rz    = (in_op == OP_SPHERE) ? in_rx : ((in_op == OP_ELLIPSOID) ? in_rz : '0);
        sel_bx    = (in_op == OP_BOX) ? in_bx : in_ax;
        sel_by    = (in_op == OP_BOX) ? in_by : in_ay;
        sel_bz    = (in_op == OP_BOX) ? in_bz : in_az;
        sx        = clip_span(in_ax, sel_bx, sel_rx, GRID_X);
        sy        = clip_span(in_ay, sel_by, sel_ry, GRID_Y);
        sz        = clip_span(in_az, sel_bz, sel_rz, GRID_Z);
        any_empty = sx.empty || sy.empty || sz.empty;
    end

    // Command registers.
    logic                      walk_empty_reg;
    logic                      read_ok_reg;
    logic                      reject_reg;
    logic                      erase_reg;
    vsr_kind_t                 kind_reg;
    logic signed [COORD_W-1:0] cx_reg, cy_reg, cz_reg;
    logic [RAD_W-1:0]          rx_reg, ry_reg, rz_reg;
    logic [XW-1:0]             x1_reg, x_reg;
    logic [YW-1:0]             y0_reg, y1_reg, y_reg;
    logic [ZW-1:0]             z0_reg, z1_reg, z_reg;
    logic [AW-1:0]             raddr_reg;
    logic [SQ_W-1:0]           rx2_reg, ry2_reg, rz2_reg;
    logic [PAIR_W-1:0]         ryz_reg, rxz_reg, rxy_reg;
    logic [TRIP_W-1:0]         rxyz_reg;
    logic                      walk_last;

    assign walk_last = (x_reg == x1_reg) && (y_reg == y1_reg) && (z_reg == z1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_empty_reg <= 1'b1;
            read_ok_reg    <= 1'b0;
            reject_reg     <= 1'b0;
        end
        else if (cmd.load)
        begin
            walk_empty_reg <= !walks_op || any_empty;
            read_ok_reg    <= (in_op == OP_READ) && !any_empty;
            reject_reg     <= is_reject;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            erase_reg <= in_erase;
            case (in_op)
                OP_SPHERE:    kind_reg <= KIND_SPHERE;
                OP_ELLIPSOID: kind_reg <= KIND_ELLIPSOID;
                default:      kind_reg <= KIND_BOX;
            endcase
            cx_reg    <= in_ax;
            cy_reg    <= in_ay;
            cz_reg    <= in_az;
            rx_reg    <= in_rx;
            ry_reg    <= in_ry;
            rz_reg    <= in_rz;
            x1_reg    <= sx.hi[XW-1:0];
            y0_reg    <= sy.lo[YW-1:0];
            y1_reg    <= sy.hi[YW-1:0];
            z0_reg    <= sz.lo[ZW-1:0];
            z1_reg    <= sz.hi[ZW-1:0];
            x_reg     <= sx.lo[XW-1:0];
            y_reg     <= sy.lo[YW-1:0];
            z_reg     <= sz.lo[ZW-1:0];
            raddr_reg <= {in_ax[XW-1:0], in_ay[YW-1:0], in_az[ZW-1:0]};
        end
        else if (cmd.walk_en)
        begin
            if (z_reg != z1_reg)
            begin
                z_reg <= z_reg + 1'b1;
            end
            else
            begin
                z_reg <= z0_reg;
                if (y_reg != y1_reg)
                begin
                    y_reg <= y_reg + 1'b1;
                end
                else
                begin
                    y_reg <= y0_reg;
                    x_reg <= x_reg + 1'b1;
                end
            end
        end

        // Radius squares and products for the sphere and ellipsoid tests, one multiply level per step.
        if (cmd.sq_en)
        begin
            rx2_reg <= SQ_W'(rx_reg) * SQ_W'(rx_reg);
            ry2_reg <= SQ_W'(ry_reg) * SQ_W'(ry_reg);
            rz2_reg <= SQ_W'(rz_reg) * SQ_W'(rz_reg);
        end
        if (cmd.pair_en)
        begin
            ryz_reg <= PAIR_W'(ry2_reg) * PAIR_W'(rz2_reg);
            rxz_reg <= PAIR_W'(rx2_reg) * PAIR_W'(rz2_reg);
            rxy_reg <= PAIR_W'(rx2_reg) * PAIR_W'(ry2_reg);
        end
        if (cmd.trip_en)
        begin
            rxyz_reg <= TRIP_W'(rx2_reg) * TRIP_W'(ryz_reg);
        end
    end

    // Hit pipeline: offsets, squares, products, compare, then the store write.
    logic              p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_we_reg;
    logic [AW-1:0]     p1_addr_reg, p2_addr_reg, p3_addr_reg, p4_addr_reg;
    logic [RAD_W-1:0]  p1_ax_reg, p1_ay_reg, p1_az_reg;
    logic [SQ_W-1:0]   p2_qx_reg, p2_qy_reg, p2_qz_reg;
    logic [TRIP_W-1:0] p3_px_reg, p3_py_reg, p3_pz_reg;
    logic              p3_sph_reg;
    logic              hit;

    logic signed [WIDE_W-1:0] dx, dy, dz;

    assign dx = $signed({{(WIDE_W-XW){1'b0}}, x_reg}) - WIDE_W'(cx_reg);
    assign dy = $signed({{(WIDE_W-YW){1'b0}}, y_reg}) - WIDE_W'(cy_reg);
    assign dz = $signed({{(WIDE_W-ZW){1'b0}}, z_reg}) - WIDE_W'(cz_reg);

    always_comb
    begin
        case (kind_reg)
            KIND_BOX:       hit = 1'b1;
            KIND_SPHERE:    hit = p3_sph_reg;
            KIND_ELLIPSOID: hit = (ESUM_W'(p3_px_reg) + ESUM_W'(p3_py_reg) +
                                   ESUM_W'(p3_pz_reg)) <= ESUM_W'(rxyz_reg);
            default:        hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_we_reg    <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= cmd.walk_en;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_we_reg    <= p3_valid_reg && hit;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_addr_reg <= {x_reg, y_reg, z_reg};
        p1_ax_reg   <= abs_low(dx);
        p1_ay_reg   <= abs_low(dy);
        p1_az_reg   <= abs_low(dz);
        p2_addr_reg <= p1_addr_reg;
        p2_qx_reg   <= SQ_W'(p1_ax_reg) * SQ_W'(p1_ax_reg);
        p2_qy_reg   <= SQ_W'(p1_ay_reg) * SQ_W'(p1_ay_reg);
        p2_qz_reg   <= SQ_W'(p1_az_reg) * SQ_W'(p1_az_reg);
        p3_addr_reg <= p2_addr_reg;
        p3_px_reg   <= TRIP_W'(p2_qx_reg) * TRIP_W'(ryz_reg);
        p3_py_reg   <= TRIP_W'(p2_qy_reg) * TRIP_W'(rxz_reg);
        p3_pz_reg   <= TRIP_W'(p2_qz_reg) * TRIP_W'(rxy_reg);
        p3_sph_reg  <= (SUM_W'(p2_qx_reg) + SUM_W'(p2_qy_reg) + SUM_W'(p2_qz_reg)) <=
                       SUM_W'(rx2_reg);
        p4_addr_reg <= p3_addr_reg;
    end

    // Configuration registers.
    logic [COLOR_W-1:0] draw_red_reg, draw_green_reg, draw_blue_reg, draw_alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draw_red_reg   <= COLOR_RESET;
            draw_green_reg <= COLOR_RESET;
            draw_blue_reg  <= COLOR_RESET;
            draw_alpha_reg <= COLOR_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_RED:   draw_red_reg   <= cfg_wdata;
                CFG_GREEN: draw_green_reg <= cfg_wdata;
                CFG_BLUE:  draw_blue_reg  <= cfg_wdata;
                CFG_ALPHA: draw_alpha_reg <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    // Clearing pass address after reset.
    logic [AW-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_en)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // The visible flag and the colour sit in separate stores so that an erase
    // leaves the colour untouched.
    logic          vis_we, col_we;
    logic [AW-1:0] st_waddr;
    logic          vis_wdata, vis_rdata;
    logic [CW-1:0] col_wdata, col_rdata;

    assign vis_we    = cmd.clr_en || p4_we_reg;
    assign col_we    = cmd.clr_en || (p4_we_reg && !erase_reg);
    assign st_waddr  = cmd.clr_en ? clr_addr_reg : p4_addr_reg;
    assign vis_wdata = cmd.clr_en ? 1'b0 : !erase_reg;
    assign col_wdata = cmd.clr_en ? '0 :
                       {draw_alpha_reg, draw_blue_reg, draw_green_reg, draw_red_reg};

    vsr_ram #(
        .WIDTH(1),
        .DEPTH(DEPTH)
    ) u_vis_ram (
        .clk  (clk),
        .we   (vis_we),
        .waddr(st_waddr),
        .wdata(vis_wdata),
        .raddr(raddr_reg),
        .rdata(vis_rdata)
    );

    vsr_ram #(
        .WIDTH(CW),
        .DEPTH(DEPTH)
    ) u_col_ram (
        .clk  (clk),
        .we   (col_we),
        .waddr(st_waddr),
        .wdata(col_wdata),
        .raddr(raddr_reg),
        .rdata(col_rdata)
    );

    // Result register.
    logic          out_valid_reg;
    logic          out_status_reg;
    logic          out_visible_reg;
    logic [CW-1:0] out_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            out_status_reg  <= reject_reg ? STATUS_REJECT : STATUS_DONE;
            out_visible_reg <= read_ok_reg && vis_rdata;
            out_color_reg   <= read_ok_reg ? col_rdata : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-CW-1){1'b0}}, out_color_reg, out_visible_reg};
    assign m_tuser  = out_status_reg;

    always_comb
    begin
        stat            = '0;
        stat.clr_last   = &clr_addr_reg;
        stat.walk_empty = walk_empty_reg;
        stat.walk_last  = walk_last;
        stat.pipe_busy  = p1_valid_reg || p2_valid_reg || p3_valid_reg || p4_we_reg;
        stat.out_free   = !out_valid_reg || m_tready;
    end

endmodule

// ===== rtl/voxel_shape_rasterizer_core.sv =====
// Top level of the voxel shape rasterizer: sequencer, datapath and checks.
//
// Channel  Direction  Handshake            Contents
// s_*      in         s_tvalid / s_tready  one command: coordinates, radii, operation, erase
// m_*      out        m_tvalid / m_tready  one result: visible flag, colour, status
// cfg_*    in         cfg_wr_en            draw colour registers, written by index
//
// After reset a clearing pass writes all 2^(XW+YW+ZW) store entries (32768 for a
// 32 x 32 x 32 grid), one per cycle, with s_tready low meanwhile.
// A read, a rejected ellipsoid or a command with an empty clipped volume goes through the
// square, pair and triple steps straight to the result load; a shape then walks its
// clipped bounding volume, the walk counter issuing one voxel a cycle into the hit pipeline
// that feeds each store's single write port, then drains before the result load.
// One command is in work at a time; a waiting result does not hold off the next
// transfer, and a low m_tready stalls only the final result load.
module voxel_shape_rasterizer_core
    import vsr_pkg::*;
#(
    parameter int GRID_X = GRID_X_DEF,
    parameter int GRID_Y = GRID_Y_DEF,
    parameter int GRID_Z = GRID_Z_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // ax, ay, az, bx, by, bz (10 each), rad_x, rad_y, rad_z (8 each), zero fill
    input  logic [S_DATA_W-1:0] s_tdata,
    // operation (3), erase (1)
    input  logic [S_USER_W-1:0] s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // visible (1), red, green, blue, alpha (8 each), zero fill
    output logic [M_DATA_W-1:0] m_tdata,
    // status (1)
    output logic [M_USER_W-1:0] m_tuser,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_addr,
    input  logic [COLOR_W-1:0]  cfg_wdata
);

    vsr_cmd_t  cmd;
    vsr_stat_t stat;

    vsr_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    vsr_datapath #(
        .GRID_X(GRID_X),
        .GRID_Y(GRID_Y),
        .GRID_Z(GRID_Z)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // A result is loaded only into a free output register.
    a_result_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |-> stat.out_free)
        else $error("result loaded while the previous one is still waiting");

    // A new command never starts while writes of the last one are in flight.
    a_load_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !stat.pipe_busy)
        else $error("command accepted with store writes pending");

    // The walk runs only for a non-empty volume and never during the clearing pass.
    a_walk_sane: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_en |-> (!stat.walk_empty && !cmd.clr_en))
        else $error("walk step issued for an empty volume or during clearing");

    // A loaded result is presented on the next cycle.
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |=> m_tvalid)
        else $error("loaded result not presented");

endmodule
